>>> hw/rtl/bgra_pixel_format_converter_macros.svh
// Assertion macros for the BGRA pixel format converter.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef BGRA_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define BGRA_PIXEL_FORMAT_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

`define BPFC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define BPFC_ASSERT(lbl, prop, msg) \
  `BPFC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define BPFC_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define BPFC_ASSERT(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/bpfc_pkg.sv
// Package for the BGRA pixel format converter: mode codes, payload types
// and byte count constants. No dependencies.
`default_nettype none

package bpfc_pkg;

  typedef enum logic [3:0] {
    MODE_RGBA8888   = 4'd0,
    MODE_BGRA8888   = 4'd1,
    MODE_ARGB8888   = 4'd2,
    MODE_ABGR8888   = 4'd3,
    MODE_RGB888     = 4'd4,
    MODE_BGR888     = 4'd5,
    MODE_RGB565     = 4'd6,
    MODE_RGB565SWAP = 4'd7,
    MODE_RGB555     = 4'd8,
    MODE_RGB555SWAP = 4'd9,
    MODE_BGR233     = 4'd10
  } pixel_mode_e;

  localparam int unsigned ModeWidth  = 4;
  localparam int unsigned CountWidth = 3;

  localparam logic [CountWidth-1:0] Count1 = 3'd1;
  localparam logic [CountWidth-1:0] Count2 = 3'd2;
  localparam logic [CountWidth-1:0] Count3 = 3'd3;
  localparam logic [CountWidth-1:0] Count4 = 3'd4;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] alpha_in;
  } src_pixel_t;

  typedef struct packed {
    logic [31:0]           pixel_bytes;
    logic [CountWidth-1:0] byte_count;
  } dst_pixel_t;

endpackage

`default_nettype wire

>>> hw/rtl/bpfc_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the pixel input and output channels of the converter.
`default_nettype none

interface bpfc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bgra_pixel_format_converter.sv
// Each accepted item passes through an input register and then a result register before output valid.
// Throughput: one item per cycle; the only limit is downstream backpressure.
// Reset: asynchronous, active low; clears both stage valids and sets the mode to bgra8888.
// Payload registers are not reset.
// Depends on bpfc_pkg, bpfc_stream_if and the assertion macro header.
`default_nettype none

`include "bgra_pixel_format_converter_macros.svh"

module bgra_pixel_format_converter
  import bpfc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [ModeWidth-1:0] cfg_wdata_i,
  bpfc_stream_if.sink               pix_i,
  bpfc_stream_if.source             pix_o
);

  pixel_mode_e mode_q;
  logic        s1_valid_q;
  src_pixel_t  s1_data_q;
  logic        out_valid_q;
  dst_pixel_t  out_data_q;
  dst_pixel_t  out_data_d;
  logic        out_free;
  logic        s1_free;

  // Each stage takes a new item when it is empty or its content moves on.
  assign out_free    = !out_valid_q || pix_o.ready;
  assign s1_free     = !s1_valid_q || out_free;
  assign pix_i.ready = s1_free;
  assign pix_o.valid = out_valid_q;
  assign pix_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BGRA8888;
    end else if (cfg_we_i) begin
      mode_q <= pixel_mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pix_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && pix_i.valid) begin
      s1_data_q <= pix_i.data;
    end
    if (out_free && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
    b = s1_data_q.blue_in;
    g = s1_data_q.green_in;
    r = s1_data_q.red_in;
    a = s1_data_q.alpha_in;
    case (mode_q)
      MODE_RGBA8888: begin
        out_data_d = '{pixel_bytes: {a, b, g, r}, byte_count: Count4};
      end
      MODE_ARGB8888: begin
        out_data_d = '{pixel_bytes: {b, g, r, a}, byte_count: Count4};
      end
      MODE_ABGR8888: begin
        out_data_d = '{pixel_bytes: {r, g, b, a}, byte_count: Count4};
      end
      MODE_RGB888: begin
        out_data_d = '{pixel_bytes: {8'h00, b, g, r}, byte_count: Count3};
      end
      MODE_BGR888: begin
        out_data_d = '{pixel_bytes: {8'h00, r, g, b}, byte_count: Count3};
      end
      MODE_RGB565: begin
        out_data_d = '{pixel_bytes: {16'h0000, r[7:3], g[7:2], b[7:3]},
                       byte_count: Count2};
      end
      // Swapped variants store the same 16-bit word high byte first.
      MODE_RGB565SWAP: begin
        out_data_d = '{pixel_bytes: {16'h0000, g[4:2], b[7:3], r[7:3], g[7:5]},
                       byte_count: Count2};
      end
      MODE_RGB555: begin
        out_data_d = '{pixel_bytes: {17'h00000, r[7:3], g[7:3], b[7:3]},
                       byte_count: Count2};
      end
      MODE_RGB555SWAP: begin
        out_data_d = '{pixel_bytes: {16'h0000, g[5:3], b[7:3], 1'b0, r[7:3], g[7:6]},
                       byte_count: Count2};
      end
      MODE_BGR233: begin
        out_data_d = '{pixel_bytes: {24'h000000, b[7:6], g[7:5], r[7:5]},
                       byte_count: Count1};
      end
      // Bgra8888 and the unassigned codes pass the pixel through.
      default: begin
        out_data_d = '{pixel_bytes: {a, r, g, b}, byte_count: Count4};
      end
    endcase
  end

  `BPFC_ASSERT(a_count_range,
      pix_o.valid |-> (pix_o.data.byte_count == Count1 || pix_o.data.byte_count == Count2 ||
                       pix_o.data.byte_count == Count3 || pix_o.data.byte_count == Count4),
      "byte count out of range")
  `BPFC_ASSERT(a_unused_lanes_zero,
      pix_o.valid |-> ((pix_o.data.byte_count == Count4) ||
                       (pix_o.data.byte_count == Count3 &&
                        pix_o.data.pixel_bytes[31:24] == 8'h00) ||
                       (pix_o.data.byte_count == Count2 &&
                        pix_o.data.pixel_bytes[31:16] == 16'h0000) ||
                       (pix_o.data.byte_count == Count1 &&
                        pix_o.data.pixel_bytes[31:8] == 24'h000000)),
      "unused byte lanes not zero")
  `BPFC_ASSERT(a_stage_moves, (s1_valid_q && out_free) |=> out_valid_q, "item lost between stages")
  `BPFC_ASSERT(a_stage_holds,
      (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_data_q)),
      "stalled item dropped")

endmodule

`default_nettype wire
